// File: rtl/tiap_pkg.sv
`timescale 1ns / 1ps

package tiap_pkg;

    // Width of the internal saturating counters
    localparam int COUNT_WIDTH = 16;
    localparam int REPORT_WIDTH = 16;

    localparam logic [7:0] CMD_IAC  = 8'd255;
    localparam logic [7:0] CMD_DONT = 8'd254;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_SB   = 8'd250;
    localparam logic [7:0] CMD_SE   = 8'd240;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_IAC    = 3'd1,
        PH_VERB   = 3'd2,
        PH_SBOPT  = 3'd3,
        PH_SBDATA = 3'd4,
        PH_SBIAC  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_OPTION  = 3'd2,
        KIND_SUBBYTE = 3'd3,
        KIND_SUBEND  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_last;
    } rx_item_t;

    typedef struct packed {
        kind_t                   result_kind;
        logic [7:0]              out_byte;
        logic [1:0]              verb;
        logic [7:0]              sub_option;
        logic [REPORT_WIDTH-1:0] sub_length;
        logic                    buffer_end;
        logic [REPORT_WIDTH-1:0] kept_count;
    } res_item_t;

    // Classified beat handed from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] obyte;
        logic [1:0] verb;
        logic [7:0] sopt;
        logic       pay_clr;
        logic       last;
    } cls_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
    endfunction

    function automatic logic [REPORT_WIDTH-1:0] clamp_report(input count_t v);
        logic [COUNT_WIDTH+REPORT_WIDTH-1:0] ext;
        logic [COUNT_WIDTH+REPORT_WIDTH-1:0] lim;
        ext = {{REPORT_WIDTH{1'b0}}, v};
        lim = {{COUNT_WIDTH{1'b0}}, {REPORT_WIDTH{1'b1}}};
        return (ext > lim) ? {REPORT_WIDTH{1'b1}} : ext[REPORT_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/tiap_front.sv
`timescale 1ns / 1ps

module tiap_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  tiap_pkg::rx_item_t rx_item,
    output logic              push,
    output tiap_pkg::cls_t    push_data,
    input  logic              full
);
    import tiap_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [1:0] verb_reg, verb_next;
    logic [7:0] opt_reg, opt_next;
    logic [7:0] b;

    assign rx_ready = !full;
    assign push     = rx_valid && rx_ready;
    assign b        = rx_item.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            verb_reg  <= 2'd0;
            opt_reg   <= 8'd0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            verb_reg  <= verb_next;
            opt_reg   <= opt_next;
        end
    end

    always_comb
    begin
        phase_next        = PH_NORMAL;
        verb_next         = verb_reg;
        opt_next          = opt_reg;
        push_data.kind    = KIND_NONE;
        push_data.obyte   = 8'd0;
        push_data.verb    = 2'd0;
        push_data.sopt    = 8'd0;
        push_data.pay_clr = 1'b0;
        push_data.last    = rx_item.buffer_last;
        case (phase_reg)
            PH_IAC:
            begin
                if (b == CMD_IAC)
                begin
                    push_data.kind  = KIND_DATA;
                    push_data.obyte = CMD_IAC;
                end
                else if (b == CMD_WILL)
                begin
                    verb_next  = VERB_WILL;
                    phase_next = PH_VERB;
                end
                else if (b == CMD_WONT)
                begin
                    verb_next  = VERB_WONT;
                    phase_next = PH_VERB;
                end
                else if (b == CMD_DO)
                begin
                    verb_next  = VERB_DO;
                    phase_next = PH_VERB;
                end
                else if (b == CMD_DONT)
                begin
                    verb_next  = VERB_DONT;
                    phase_next = PH_VERB;
                end
                else if (b == CMD_SB)
                begin
                    phase_next = PH_SBOPT;
                end
            end
            PH_VERB:
            begin
                push_data.kind  = KIND_OPTION;
                push_data.obyte = b;
                push_data.verb  = verb_reg;
            end
            PH_SBOPT:
            begin
                opt_next          = b;
                push_data.pay_clr = 1'b1;
                phase_next        = PH_SBDATA;
            end
            PH_SBDATA:
            begin
                if (b == CMD_IAC)
                begin
                    phase_next = PH_SBIAC;
                end
                else
                begin
                    push_data.kind  = KIND_SUBBYTE;
                    push_data.obyte = b;
                    push_data.sopt  = opt_reg;
                    phase_next      = PH_SBDATA;
                end
            end
            PH_SBIAC:
            begin
                if (b == CMD_IAC)
                begin
                    push_data.kind  = KIND_SUBBYTE;
                    push_data.obyte = CMD_IAC;
                    push_data.sopt  = opt_reg;
                    phase_next      = PH_SBDATA;
                end
                else if (b == CMD_SE)
                begin
                    push_data.kind = KIND_SUBEND;
                    push_data.sopt = opt_reg;
                end
            end
            default:
            begin
                if (b == CMD_IAC)
                begin
                    phase_next = PH_IAC;
                end
                else
                begin
                    push_data.kind  = KIND_DATA;
                    push_data.obyte = b;
                end
            end
        endcase
    end

endmodule

// File: rtl/tiap_fifo.sv
`timescale 1ns / 1ps

module tiap_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tiap_pkg::cls_t push_data,
    output logic           full,
    input  logic           pop,
    output tiap_pkg::cls_t pop_data,
    output logic           not_empty
);
    import tiap_pkg::*;

    cls_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/tiap_back.sv
`timescale 1ns / 1ps

module tiap_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  tiap_pkg::cls_t      pop_data,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output tiap_pkg::res_item_t res_item
);
    import tiap_pkg::*;

    count_t    pay_reg, pay_next;
    count_t    data_reg, data_next;
    count_t    data_inc;
    logic      valid_reg;
    res_item_t item_reg, item_next;

    assign pop       = not_empty && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res_item  = item_reg;

    always_comb
    begin
        pay_next = pay_reg;
        if (pop_data.pay_clr)
        begin
            pay_next = '0;
        end
        else if (pop_data.kind == KIND_SUBBYTE)
        begin
            pay_next = sat_inc(pay_reg);
        end

        data_inc  = (pop_data.kind == KIND_DATA) ? sat_inc(data_reg) : data_reg;
        data_next = pop_data.last ? '0 : data_inc;

        item_next.result_kind = pop_data.kind;
        item_next.out_byte    = pop_data.obyte;
        item_next.verb        = pop_data.verb;
        item_next.sub_option  = pop_data.sopt;
        item_next.sub_length  = (pop_data.kind == KIND_SUBEND) ?
                                clamp_report(pay_reg) : '0;
        item_next.buffer_end  = pop_data.last;
        item_next.kept_count  = pop_data.last ? clamp_report(data_inc) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pay_reg   <= '0;
            data_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pay_reg   <= pay_next;
                data_reg  <= data_next;
                valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/telnet_iac_parser.sv
`timescale 1ns / 1ps
// Telnet IAC parser: strips telnet commands from a received byte stream.
// rx channel (rx_valid/rx_ready/rx_item): one stream byte per beat, with
//   buffer_last marking the final byte of a received buffer.
// res channel (res_valid/res_ready/res_item): exactly one result beat per
//   rx beat, in order. result_kind tells data byte, option event,
//   subnegotiation byte, subnegotiation end, or nothing (command bytes).
// The front classifies each byte against the command phase and pushes the
//   classified beat into a two-entry queue; the back keeps the payload and
//   data counters and loads the output register.
// The rx beat is written into the queue when it is accepted; the back then
//   moves it into the output register, which drives res_valid.
// Throughput: one byte per cycle sustained while res_ready stays high, set by
//   the phase update in the front and the counter update in the back.
// Reset: phase, counters and queue are cleared; no result is pending.
// When the receiver stalls the output register holds, the queue fills and
//   rx_ready drops only once both queue entries are occupied.
module telnet_iac_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  tiap_pkg::rx_item_t  rx_item,
    output logic                res_valid,
    input  logic                res_ready,
    output tiap_pkg::res_item_t res_item
);
    import tiap_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic not_empty;
    cls_t push_data;
    cls_t pop_data;

    // Classify bytes and track the command phase
    tiap_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Decouple the two halves so either may stall
    tiap_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    // Count payload and data bytes, drive the result beat
    tiap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

// File: test/telnet_iac_checker.sv
`timescale 1ns / 1ps

module tiap_checker
    import tiap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rx_valid,
    input  logic      rx_ready,
    input  rx_item_t  rx_item,
    input  logic      res_valid,
    input  logic      res_ready,
    input  res_item_t res_item,
    output int        failures,
    output int        pending
);

    localparam longint unsigned COUNT_TOP  = (64'd1 << COUNT_WIDTH) - 1;
    localparam longint unsigned REPORT_TOP = (64'd1 << REPORT_WIDTH) - 1;

    // Predicted parser state
    phase_t           cmd_phase;
    verb_t            held_verb;
    logic [7:0]       held_option;
    longint unsigned  payload_n;
    longint unsigned  data_n;

    res_item_t        expected_results[$];
    int               results_seen;

    initial
    begin
        failures = 0;
        pending = 0;
        results_seen = 0;
    end

    function automatic longint unsigned bump(input longint unsigned v);
        return (v >= COUNT_TOP) ? v : v + 1;
    endfunction

    function automatic logic [REPORT_WIDTH-1:0] as_report(input longint unsigned v);
        return (v > REPORT_TOP) ? '1 : REPORT_WIDTH'(v);
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: result %0d: %s got %0d want %0d",
                 $realtime, results_seen, what, got, want);
        failures++;
    endtask

    task automatic parse_byte(input rx_item_t it, output res_item_t r);
        logic [7:0] b;
        b = it.rx_byte;
        r = '0;
        case (cmd_phase)
            PH_IAC:
            begin
                case (b)
                    CMD_IAC:
                    begin
                        r.result_kind = KIND_DATA;
                        r.out_byte = CMD_IAC;
                        cmd_phase = PH_NORMAL;
                    end
                    CMD_WILL:
                    begin
                        held_verb = VERB_WILL;
                        cmd_phase = PH_VERB;
                    end
                    CMD_WONT:
                    begin
                        held_verb = VERB_WONT;
                        cmd_phase = PH_VERB;
                    end
                    CMD_DO:
                    begin
                        held_verb = VERB_DO;
                        cmd_phase = PH_VERB;
                    end
                    CMD_DONT:
                    begin
                        held_verb = VERB_DONT;
                        cmd_phase = PH_VERB;
                    end
                    CMD_SB:  cmd_phase = PH_SBOPT;
                    default: cmd_phase = PH_NORMAL;
                endcase
            end
            PH_VERB:
            begin
                r.result_kind = KIND_OPTION;
                r.out_byte = b;
                r.verb = held_verb;
                cmd_phase = PH_NORMAL;
            end
            PH_SBOPT:
            begin
                held_option = b;
                payload_n = 0;
                cmd_phase = PH_SBDATA;
            end
            PH_SBDATA:
            begin
                if (b == CMD_IAC)
                begin
                    cmd_phase = PH_SBIAC;
                end
                else
                begin
                    r.result_kind = KIND_SUBBYTE;
                    r.out_byte = b;
                    r.sub_option = held_option;
                    payload_n = bump(payload_n);
                end
            end
            PH_SBIAC:
            begin
                if (b == CMD_IAC)
                begin
                    r.result_kind = KIND_SUBBYTE;
                    r.out_byte = CMD_IAC;
                    r.sub_option = held_option;
                    payload_n = bump(payload_n);
                    cmd_phase = PH_SBDATA;
                end
                else if (b == CMD_SE)
                begin
                    r.result_kind = KIND_SUBEND;
                    r.sub_option = held_option;
                    r.sub_length = as_report(payload_n);
                    cmd_phase = PH_NORMAL;
                end
                else
                begin
                    cmd_phase = PH_NORMAL;
                end
            end
            default:
            begin
                if (b == CMD_IAC)
                begin
                    cmd_phase = PH_IAC;
                end
                else
                begin
                    r.result_kind = KIND_DATA;
                    r.out_byte = b;
                    cmd_phase = PH_NORMAL;
                end
            end
        endcase
        if (r.result_kind == KIND_DATA)
            data_n = bump(data_n);
        r.buffer_end = it.buffer_last;
        if (it.buffer_last)
        begin
            r.kept_count = as_report(data_n);
            data_n = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t predicted;
        res_item_t want;
        if (!rst_n)
        begin
            cmd_phase = PH_NORMAL;
            held_verb = VERB_WILL;
            held_option = '0;
            payload_n = 0;
            data_n = 0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (rx_valid && rx_ready)
            begin
                parse_byte(rx_item, predicted);
                expected_results.push_back(predicted);
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected beat, kind", res_item.result_kind, 0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_item.result_kind !== want.result_kind)
                        report_mismatch("result_kind", res_item.result_kind,
                                        want.result_kind);
                    if (res_item.out_byte !== want.out_byte)
                        report_mismatch("out_byte", res_item.out_byte, want.out_byte);
                    if (res_item.verb !== want.verb)
                        report_mismatch("verb", res_item.verb, want.verb);
                    if (res_item.sub_option !== want.sub_option)
                        report_mismatch("sub_option", res_item.sub_option, want.sub_option);
                    if (res_item.sub_length !== want.sub_length)
                        report_mismatch("sub_length", res_item.sub_length, want.sub_length);
                    if (res_item.buffer_end !== want.buffer_end)
                        report_mismatch("buffer_end", res_item.buffer_end, want.buffer_end);
                    if (res_item.kept_count !== want.kept_count)
                        report_mismatch("kept_count", res_item.kept_count, want.kept_count);
                end
                results_seen++;
            end
            pending = expected_results.size();
        end
    end

endmodule

// File: test/tb_telnet_iac_parser.sv
`timescale 1ns / 1ps

module tb_telnet_iac_parser;

    import tiap_pkg::*;

    // Generous ceiling for some 800 beats with idling and one long hold-off.
    localparam int CYCLE_LIMIT  = 50000;
    localparam int IDLE_PERCENT = 18;
    localparam int RANDOM_BEATS = 760;
    localparam int HOLD_CYCLES  = 150;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      rx_valid = 1'b0;
    logic      rx_ready;
    rx_item_t  rx_item = '0;
    logic      res_valid;
    logic      res_ready = 1'b0;
    res_item_t res_item;

    int        failures;
    int        pending;

    // Shared state of the sender, receiver and watchdog processes
    int        beats_sent = 0;
    bit        calm = 1'b0;      // no idling on either side while set
    bit        hold_req = 1'b0;  // ask the receiver for its long hold-off
    int        cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    telnet_iac_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    tiap_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .failures  (failures),
        .pending   (pending)
    );

    // Offer one byte and hold it until the block takes it. Idle cycles are
    // inserted before the offer, never while valid is up, so the payload
    // stays stable until the beat completes.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_item <= '{rx_byte: b, buffer_last: last};
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    function automatic logic coin_last();
        return ($urandom_range(7) == 0);
    endfunction

    // Any byte except IAC; IAC has to go out doubled to stay literal.
    function automatic logic [7:0] plain_byte();
        return 8'($urandom_range(254));
    endfunction

    // Send one payload byte, doubling IAC so it stays in the payload.
    task automatic send_payload_byte(input logic [7:0] b);
        if (b == CMD_IAC)
            send_beat(CMD_IAC, coin_last());
        send_beat(b, coin_last());
    endtask

    // One telnet sequence with random content. Most are well formed; a
    // share are broken subnegotiations or raw noise to drive odd corners.
    task automatic send_random_sequence();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            send_beat(plain_byte(), coin_last());
        end
        else if (pick < 45)
        begin
            send_beat(CMD_IAC, coin_last());
            send_beat(CMD_IAC, coin_last());
        end
        else if (pick < 65)
        begin
            send_beat(CMD_IAC, coin_last());
            case ($urandom_range(3))
                0:       send_beat(CMD_WILL, coin_last());
                1:       send_beat(CMD_WONT, coin_last());
                2:       send_beat(CMD_DO, coin_last());
                default: send_beat(CMD_DONT, coin_last());
            endcase
            send_beat(8'($urandom_range(255)), coin_last());
        end
        else if (pick < 90)
        begin
            send_beat(CMD_IAC, coin_last());
            send_beat(CMD_SB, coin_last());
            send_beat(8'($urandom_range(255)), coin_last());
            len = $urandom_range(6);
            for (int i = 0; i < len; i++)
                send_payload_byte(8'($urandom_range(255)));
            send_beat(CMD_IAC, coin_last());
            if ($urandom_range(9) < 8)
            begin
                send_beat(CMD_SE, coin_last());
            end
            else
            begin
                // Abandon the subnegotiation with some other command byte
                b = plain_byte();
                if (b == CMD_SE)
                    b = b + 8'd1;
                send_beat(b, coin_last());
            end
        end
        else
        begin
            send_beat(8'($urandom_range(255)), coin_last());
        end
    endtask

    // Receiver: random back-pressure, a calm stretch, and once a long
    // hold-off counted here so the internal queue fills and rx_ready drops.
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_ready <= 1'b0;
            end
            else if (calm)
            begin
                res_ready <= 1'b1;
            end
            else
            begin
                res_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: end the run if it overstays the ceiling.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int base;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain-byte extremes and a buffer end
        send_beat(8'h00, 1'b0);
        send_beat(8'hfe, 1'b1);
        // Escaped IAC gives a data byte 255
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        // Every verb, option codes at both ends, buffer end on an option
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_WILL, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_WONT, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_DO, 1'b0);
        send_beat(8'd24, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_DONT, 1'b0);
        send_beat(8'hff, 1'b1);
        // Unknown command: IAC SE outside a subnegotiation is dropped
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_SE, 1'b0);
        // Empty payload; buffer boundary mid-command must not reset phase
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_SB, 1'b1);
        send_beat(8'd31, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_SE, 1'b0);
        // One-byte payload that is a literal IAC
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_SB, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_SE, 1'b1);
        // Other command inside a payload abandons it without a report
        send_beat(CMD_IAC, 1'b0);
        send_beat(CMD_SB, 1'b0);
        send_beat(8'd7, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(CMD_IAC, 1'b0);
        send_beat(8'h01, 1'b1);

        // Random sequences: one long hold-off early, then a calm stretch
        base = beats_sent;
        while (beats_sent - base < RANDOM_BEATS)
        begin
            if (beats_sent - base >= 100)
                hold_req = 1'b1;
            calm = (beats_sent - base >= 300) && (beats_sent - base < 450);
            send_random_sequence();
        end
        calm = 1'b0;
        rx_valid <= 1'b0;

        // Drain: let the checker see the last beat, wait for every result,
        // then idle to catch any stray extra beat.
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/tiap_pkg.sv
rtl/tiap_front.sv
rtl/tiap_fifo.sv
rtl/tiap_back.sv
rtl/telnet_iac_parser.sv
test/telnet_iac_checker.sv
test/tb_telnet_iac_parser.sv
